/* design/utf8_slc_pkg.sv */
// Shared constants and types for the UTF-8 locator check unit.
`timescale 1ns / 1ps
package utf8_slc_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int CFG_W     = 16;
    localparam int LEN_OUT_W = 17;
    localparam int CP_W      = 21;

    typedef logic [7:0]      byte_t;
    typedef logic [CP_W-1:0] code_point_t;

    localparam byte_t CTRL_LIMIT = 8'h20;
    localparam byte_t DEL_BYTE   = 8'h7F;
    localparam byte_t LEAD2_LO   = 8'hC2;
    localparam byte_t LEAD2_HI   = 8'hDF;
    localparam byte_t LEAD3_LO   = 8'hE0;
    localparam byte_t LEAD3_HI   = 8'hEF;
    localparam byte_t LEAD4_LO   = 8'hF0;
    localparam byte_t LEAD4_HI   = 8'hF4;

    localparam code_point_t CP_MIN3   = 21'h000800;
    localparam code_point_t CP_MIN4   = 21'h010000;
    localparam code_point_t SURR_LO   = 21'h00D800;
    localparam code_point_t SURR_HI   = 21'h00DFFF;
    localparam code_point_t CP_MAX    = 21'h10FFFF;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TWO  = 2'd1;
    localparam logic [1:0] KIND_THREE = 2'd2;
    localparam logic [1:0] KIND_FOUR = 2'd3;

    localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

/* design/utf8_safe_locator_check_unit.sv */
// Streaming UTF-8 locator safety checker with a configurable length limit.
// Flow: an accepted item is held in the input register and decoded from there;
// for a last item its result is loaded into the result register seen on the master side.
// Throughput: one item per cycle unless a last item waits on a stalled master side;
// a two-entry path (input register, result register) with the combinational decode between them.
// Reset: aresetn is synchronous, active low; it clears decode state, valids and
// loads the length limit with 4096.
`timescale 1ns / 1ps
module utf8_safe_locator_check_unit
    import utf8_slc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,   // max_locator_bytes
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tlast,
    input  logic                 s_axis_tuser,  // [0] no_data
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [0] locator_safe, [17:1] locator_length
);

    localparam int CNT_W    = LENGTH_BITS + 1;
    localparam int CFG_KEEP = (LENGTH_BITS < CFG_W) ? LENGTH_BITS : CFG_W;

    logic [LENGTH_BITS-1:0] limit_reg;

    logic       in_valid_reg;
    byte_t      in_byte_reg;
    logic       in_last_reg;
    logic       in_nodata_reg;

    logic [1:0]   cont_reg, cont_next;
    logic [1:0]   kind_reg, kind_next;
    code_point_t  acc_reg, acc_next;
    logic         err_reg, err_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             out_valid_reg;
    logic             out_safe_reg, out_safe_next;
    logic [LEN_OUT_W-1:0] out_len_reg;

    logic         advance;
    logic         load_out;
    logic [1:0]   cont_dec;
    code_point_t  acc_shift;
    logic         bad_cp;
    logic [1:0]   cont_upd;
    logic [1:0]   kind_upd;
    code_point_t  acc_upd;
    logic         err_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic [CNT_W-1:0] limit_ext;

    assign limit_ext = {1'b0, limit_reg};

    assign load_out      = in_valid_reg && in_last_reg;
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign cont_dec  = cont_reg - 2'd1;
    assign acc_shift = {acc_reg[CP_W-7:0], in_byte_reg[5:0]};
    assign bad_cp    = (kind_reg == KIND_THREE && acc_shift < CP_MIN3) ||
                       (kind_reg == KIND_FOUR && acc_shift < CP_MIN4) ||
                       (acc_shift >= SURR_LO && acc_shift <= SURR_HI) ||
                       (acc_shift > CP_MAX);

    always_comb begin
        cont_upd = cont_reg;
        kind_upd = kind_reg;
        acc_upd  = acc_reg;
        err_upd  = err_reg;
        cnt_upd  = cnt_reg;
        if (!in_nodata_reg) begin
            if (cnt_reg <= limit_ext) begin
                cnt_upd = cnt_reg + CNT_W'(1);
            end
            if (in_byte_reg < CTRL_LIMIT || in_byte_reg == DEL_BYTE) begin
                err_upd = 1'b1;
            end
            if (cont_reg == 2'd0) begin
                if (in_byte_reg <= DEL_BYTE) begin
                    cont_upd = cont_reg;
                end else if (in_byte_reg >= LEAD2_LO && in_byte_reg <= LEAD2_HI) begin
                    acc_upd  = CP_W'(in_byte_reg[4:0]);
                    kind_upd = KIND_TWO;
                    cont_upd = KIND_TWO;
                end else if (in_byte_reg >= LEAD3_LO && in_byte_reg <= LEAD3_HI) begin
                    acc_upd  = CP_W'(in_byte_reg[3:0]);
                    kind_upd = KIND_THREE;
                    cont_upd = KIND_THREE;
                end else if (in_byte_reg >= LEAD4_LO && in_byte_reg <= LEAD4_HI) begin
                    acc_upd  = CP_W'(in_byte_reg[2:0]);
                    kind_upd = KIND_FOUR;
                    cont_upd = KIND_FOUR;
                end else begin
                    err_upd = 1'b1;
                end
            end else begin
                if (in_byte_reg[7:6] != CONT_TAG) begin
                    err_upd = 1'b1;
                end
                acc_upd  = acc_shift;
                cont_upd = cont_dec;
                if (cont_dec == 2'd0) begin
                    if (bad_cp) begin
                        err_upd = 1'b1;
                    end
                    kind_upd = KIND_NONE;
                    acc_upd  = '0;
                end
            end
        end
    end

    always_comb begin
        out_safe_next = !err_upd && cont_upd == 2'd0 &&
                        cnt_upd != '0 && cnt_upd <= limit_ext;
        if (in_last_reg) begin
            cont_next = '0;
            kind_next = KIND_NONE;
            acc_next  = '0;
            err_next  = 1'b0;
            cnt_next  = '0;
        end else begin
            cont_next = cont_upd;
            kind_next = kind_upd;
            acc_next  = acc_upd;
            err_next  = err_upd;
            cnt_next  = cnt_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LENGTH_BITS'(4096);
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cont_reg      <= '0;
            kind_reg      <= KIND_NONE;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= LENGTH_BITS'(cfg_wr_data[CFG_KEEP-1:0]);
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                cont_reg <= cont_next;
                kind_reg <= kind_next;
                acc_reg  <= acc_next;
                err_reg  <= err_next;
                cnt_reg  <= cnt_next;
            end
            if (advance && load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg   <= s_axis_tdata;
            in_last_reg   <= s_axis_tlast;
            in_nodata_reg <= s_axis_tuser;
        end
        if (advance && load_out) begin
            out_safe_reg <= out_safe_next;
            out_len_reg  <= LEN_OUT_W'(cnt_upd);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - LEN_OUT_W - 1){1'b0}}, out_len_reg, out_safe_reg};

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result appeared without a last item");

    a_safe_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_safe_reg) |-> (out_len_reg != '0))
        else $error("safe result with zero length");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (cnt_reg == '0 && cont_reg == 2'd0 && !err_reg))
        else $error("decode state not cleared after last item");

    a_idle_decoder: assert property (@(posedge aclk) disable iff (!aresetn)
        (cont_reg == 2'd0) |-> (kind_reg == KIND_NONE && acc_reg == '0))
        else $error("open sequence state without pending continuations");

endmodule
